/* hw/rtl/ecf_pkg.sv */
package ecf_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_PAIR  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // field widths
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int ADC_W    = 12;
    localparam int RAND_W   = 32;
    localparam int CFG_W    = 6;

    // stream widths; the tdata widths are whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    // gather and pool
    localparam int WORD_BITS      = 64;
    localparam int GATHER_CNT_W   = $clog2(WORD_BITS);
    localparam int ROUND_WORDS    = 8;
    localparam int ROUND_W        = $clog2(ROUND_WORDS);
    localparam logic [WORD_BITS-1:0] POOL_BASIS = 64'hcbf29ce484222325;

    // ring and queue defaults
    localparam int RING_DEPTH_DEF  = 32;
    localparam int CFG_SIZE_RESET  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // command from front to back
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_MIX,
        CMD_POP,
        CMD_FLUSH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [WORD_BITS-1:0]   operand;
    } t_cmd;

endpackage

/* hw/rtl/ecf_front.sv */
module ecf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ecf_pkg::OP_W-1:0]    i_op,
    input  logic                        i_bit_a,
    input  logic                        i_bit_b,
    input  logic [ecf_pkg::TIME_W-1:0]  i_time_ms,
    input  logic [ecf_pkg::ADC_W-1:0]   i_adc_sample,
    output logic                        o_cmd_valid,
    output ecf_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_ready
);
    import ecf_pkg::*;

    logic [WORD_BITS-1:0]    r_gather_word;
    logic [GATHER_CNT_W-1:0] r_gather_count;
    logic [WORD_BITS-1:0]    n_gather_word;
    logic [GATHER_CNT_W-1:0] n_gather_count;
    logic [WORD_BITS-1:0]    shifted;
    logic                    accept;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign accept      = i_valid && i_cmd_ready;
    assign shifted     = {r_gather_word[WORD_BITS-2:0], i_bit_a};

    // von neumann gather and command decode
    always_comb begin
        n_gather_word  = r_gather_word;
        n_gather_count = r_gather_count;
        o_cmd.kind     = CMD_NOP;
        o_cmd.operand  = '0;
        unique case (i_op)
            OP_PAIR: begin
                if (i_bit_a != i_bit_b) begin
                    if (r_gather_count == GATHER_CNT_W'(WORD_BITS - 1)) begin
                        o_cmd.kind     = CMD_MIX;
                        o_cmd.operand  = shifted
                                       ^ {{(WORD_BITS-TIME_W){1'b0}}, i_time_ms}
                                       ^ {{(WORD_BITS-ADC_W){1'b0}}, i_adc_sample};
                        n_gather_word  = '0;
                        n_gather_count = '0;
                    end else begin
                        n_gather_word  = shifted;
                        n_gather_count = r_gather_count + 1'b1;
                    end
                end
            end
            OP_READ:  o_cmd.kind = CMD_POP;
            OP_FLUSH: o_cmd.kind = CMD_FLUSH;
            default:  o_cmd.kind = CMD_NOP;
        endcase
    end

    // gather state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather_word  <= '0;
            r_gather_count <= '0;
        end else if (accept) begin
            r_gather_word  <= n_gather_word;
            r_gather_count <= n_gather_count;
        end
    end

endmodule

/* hw/rtl/ecf_queue.sv */
module ecf_queue #(
    parameter int DEPTH = ecf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  ecf_pkg::t_cmd   i_wr_cmd,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output ecf_pkg::t_cmd   o_rd_cmd
);
    import ecf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_slot [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr_en;
    logic            rd_en;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_slot[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

/* hw/rtl/ecf_back.sv */
module ecf_back #(
    parameter int RING_DEPTH = ecf_pkg::RING_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  ecf_pkg::t_cmd               i_cmd,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ecf_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_word_valid,
    output logic [ecf_pkg::RAND_W-1:0]  o_rand_word,
    output logic                        o_ring_empty,
    output logic                        o_ring_full
);
    import ecf_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int SW = $clog2(RING_DEPTH + 1);
    localparam int SIZE_RESET = (CFG_SIZE_RESET > RING_DEPTH) ? RING_DEPTH : CFG_SIZE_RESET;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_PUSH_LO,
        S_PUSH_HI,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [WORD_BITS-1:0]   r_pool;
    logic [ROUND_W-1:0]     r_round;
    logic [WORD_BITS-1:0]   r_x;
    logic [WORD_BITS-1:0]   r_sa;
    logic [WORD_BITS-1:0]   r_sb;
    logic [WORD_BITS-1:0]   r_sc;
    logic [WORD_BITS-1:0]   r_se;
    logic [WORD_BITS-1:0]   r_sf;
    logic [IW-1:0]          r_head;
    logic [IW-1:0]          r_tail;
    logic                   r_full;
    logic                   r_empty;
    logic [SW-1:0]          r_eff;
    logic                   r_out_valid;
    logic                   r_out_wvalid;
    logic                   r_out_empty;
    logic                   r_out_full;
    logic [RAND_W-1:0]      r_ring [RING_DEPTH];
    logic [RAND_W-1:0]      r_word;

    logic [IW-1:0]          n_head;
    logic [IW-1:0]          n_tail;
    logic                   n_full;
    logic                   n_empty;
    logic [IW-1:0]          head_nx;
    logic [IW-1:0]          tail_nx;
    logic [SW-1:0]          cfg_eff;
    logic [RAND_W-1:0]      push_data;
    logic                   out_free;
    logic                   take;
    logic                   pop_hit;
    logic                   push_en;
    logic                   emit;
    logic                   cfg_wr;

    assign out_free    = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_cmd_valid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign pop_hit     = take && (i_cmd.kind == CMD_POP) && !r_empty;
    assign push_en     = ((r_state == S_PUSH_LO) || (r_state == S_PUSH_HI)) && !r_full;
    assign push_data   = (r_state == S_PUSH_LO) ? r_pool[RAND_W-1:0]
                                                : r_pool[WORD_BITS-1:RAND_W];
    assign emit        = (take && (i_cmd.kind != CMD_MIX)) || ((r_state == S_DONE) && out_free);

    // ring index wrap at the active size
    assign head_nx = ((SW+1)'(r_head) + 1'b1 >= (SW+1)'(r_eff)) ? '0 : r_head + 1'b1;
    assign tail_nx = ((SW+1)'(r_tail) + 1'b1 >= (SW+1)'(r_eff)) ? '0 : r_tail + 1'b1;

    // clamp the written size to one .. RING_DEPTH
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_eff = SW'(1);
        end else if (9'(i_cfg_data) > 9'(RING_DEPTH)) begin
            cfg_eff = SW'(RING_DEPTH);
        end else begin
            cfg_eff = SW'(i_cfg_data);
        end
    end

    // ring pointers and flags for this cycle
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_full  = r_full;
        n_empty = r_empty;
        if (push_en) begin
            n_tail  = tail_nx;
            n_empty = 1'b0;
            if (tail_nx == r_head) begin
                n_full = 1'b1;
            end
        end
        if (pop_hit) begin
            n_head = head_nx;
            n_full = 1'b0;
            if (head_nx == r_tail) begin
                n_empty = 1'b1;
            end
        end
        if (take && (i_cmd.kind == CMD_FLUSH)) begin
            n_head  = r_tail;
            n_empty = 1'b1;
            n_full  = 1'b0;
        end
    end

    // sequencer, pool multiply, ring control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool       <= POOL_BASIS;
            r_round      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_full       <= 1'b0;
            r_empty      <= 1'b1;
            r_eff        <= SW'(SIZE_RESET);
            r_out_valid  <= 1'b0;
            r_out_wvalid <= 1'b0;
            r_out_empty  <= 1'b1;
            r_out_full   <= 1'b0;
        end else if (cfg_wr) begin
            r_eff   <= cfg_eff;
            r_head  <= '0;
            r_tail  <= '0;
            r_full  <= 1'b0;
            r_empty <= 1'b1;
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_full  <= n_full;
            r_empty <= n_empty;

            unique case (r_state)
                S_IDLE: begin
                    if (take && (i_cmd.kind == CMD_MIX)) begin
                        r_x     <= ((r_round == '0) ? POOL_BASIS : r_pool) ^ i_cmd.operand;
                        r_state <= S_MUL1;
                    end
                end
                // prime is 2^40 + 0x1b3: sum of shifted copies
                S_MUL1: begin
                    r_sa    <= (r_x << 40) + (r_x << 8);
                    r_sb    <= (r_x << 7) + (r_x << 5);
                    r_sc    <= (r_x << 4) + (r_x << 1);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_se    <= r_sa + r_sb;
                    r_sf    <= r_sc + r_x;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_pool <= r_se + r_sf;
                    if (r_round == ROUND_W'(ROUND_WORDS - 1)) begin
                        r_round <= '0;
                        r_state <= S_PUSH_LO;
                    end else begin
                        r_round <= r_round + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_PUSH_LO: r_state <= S_PUSH_HI;
                S_PUSH_HI: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (emit) begin
                r_out_valid  <= 1'b1;
                r_out_wvalid <= pop_hit;
                r_out_empty  <= n_empty;
                r_out_full   <= n_full;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ring write port
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_ring[r_tail] <= push_data;
        end
    end

    // ring read port, zero when no word is popped
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word <= pop_hit ? r_ring[r_head] : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_word_valid = r_out_wvalid;
    assign o_rand_word  = r_word;
    assign o_ring_empty = r_out_empty;
    assign o_ring_full  = r_out_full;

endmodule

/* hw/rtl/entropy_conditioner_fifo_top.sv */
// entropy conditioner with random word ring
//
// input stream: one beat per operation, tuser carries the op code (raw bit pair,
// read one word, flush ring). tdata carries bit_a, bit_b, time_ms and adc_sample.
// unequal bit pairs are gathered into 64-bit words; each full word is mixed
// into a 64-bit fnv-style pool, and every eighth mix pushes the pool into the
// ring as two 32-bit words, low half first. a push into a full ring is dropped.
// output stream: exactly one beat per input beat, in order. tuser is word_valid,
// tdata holds the popped word (zero if none) and the ring empty/full status.
// config channel: writes the ring size (clamped to 1..RING_DEPTH) and empties
// the ring; it is taken only while the back end is idle with no queued op.
// each input beat passes through the command queue into the back end's output register;
// a beat completing a gathered word first steps through the shift-add pool multiply
// (S_MUL1..S_MUL3) and, when it pushes, the single ring write port (S_PUSH_LO, S_PUSH_HI).
// throughput: one beat per cycle while the receiver is ready, except that such a beat holds
// the back end through those states; the queue covers these only across input gaps.
// reset clears gather state, pool (to the offset basis), ring pointers and output
// valid/status; ring size returns to min(32, RING_DEPTH). when the receiver stalls, the
// output beat holds, the queue fills and tready drops on the input side.
module entropy_conditioner_fifo_top #(
    parameter int RING_DEPTH  = ecf_pkg::RING_DEPTH_DEF,
    parameter int QUEUE_DEPTH = ecf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // bit_a, bit_b, time_ms[31:0], adc_sample[11:0], zero pad
    input  logic [ecf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  logic [ecf_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // rand_word[31:0], ring_empty, ring_full, zero pad
    output logic [ecf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // word_valid
    output logic [ecf_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ecf_pkg::CFG_W-1:0]        i_cfg_data
);
    import ecf_pkg::*;

    t_cmd               front_cmd;
    logic               front_valid;
    logic               front_ready;
    t_cmd               back_cmd;
    logic               back_valid;
    logic               back_ready;
    logic               word_valid;
    logic [RAND_W-1:0]  rand_word;
    logic               ring_empty;
    logic               ring_full;

    // front: gather and classify
    ecf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser[OP_W-1:0]),
        .i_bit_a      (s_axis_tdata[0]),
        .i_bit_b      (s_axis_tdata[1]),
        .i_time_ms    (s_axis_tdata[TIME_W+1:2]),
        .i_adc_sample (s_axis_tdata[ADC_W+TIME_W+1:TIME_W+2]),
        .o_cmd_valid  (front_valid),
        .o_cmd        (front_cmd),
        .i_cmd_ready  (front_ready)
    );

    // command queue between front and back
    ecf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_cmd   (front_cmd),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready),
        .o_rd_cmd   (back_cmd)
    );

    // back: pool mix, ring and result register
    ecf_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (back_valid),
        .o_cmd_ready  (back_ready),
        .i_cmd        (back_cmd),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_word_valid (word_valid),
        .o_rand_word  (rand_word),
        .o_ring_empty (ring_empty),
        .o_ring_full  (ring_full)
    );

    // output beat packing
    assign m_axis_tdata = {{(OUT_TDATA_W-RAND_W-2){1'b0}}, ring_full, ring_empty, rand_word};
    assign m_axis_tuser = word_valid;

endmodule

/* hw/rtl/ecf_checker.sv */
module ecf_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [ecf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [ecf_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import ecf_pkg::*;

    // no output beat right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // no word means a zero word
    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[RAND_W-1:0] == '0)
        else $error("nonzero word without word_valid");

    // a pop always leaves room
    a_pop_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[RAND_W+1])
        else $error("ring full after a pop");

    // ring cannot be empty and full at once
    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[RAND_W] && m_axis_tdata[RAND_W+1]))
        else $error("ring empty and full together");

endmodule

bind entropy_conditioner_fifo_top ecf_checker u_ecf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
